>>> design/mfp_pkg.sv
package mfp_pkg;

    localparam int unsigned PAYLOAD_BUFFER_BYTES_DEF = 256;

    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_DOLLAR  = 6'b000010,
        PH_X       = 6'b000100,
        PH_HEADER  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_OK       = 3'd2,
        EV_CRC      = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_DIR      = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_start;
    } t_in_word;

    typedef struct packed {
        logic   fire;
        t_phase phase;
    } t_core_stat;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] function_code;
        logic [15:0] payload_length;
        logic [7:0]  header_flags;
        logic        is_response;
        logic [7:0]  computed_crc;
    } t_result;

    // crc-8 dvb-s2, msb first, one byte
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

>>> design/mfp_in_if.sv
interface mfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_start;

    modport source (output valid, output data_byte, output buffer_start, input ready);
    modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

>>> design/mfp_out_if.sv
interface mfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [7:0]  header_flags;
    logic        is_response;
    logic [7:0]  computed_crc;

    modport source (
        output valid, output event_res, output payload_byte, output payload_index,
        output function_code, output payload_length, output header_flags,
        output is_response, output computed_crc, input ready
    );
    modport sink (
        input valid, input event_res, input payload_byte, input payload_index,
        input function_code, input payload_length, input header_flags,
        input is_response, input computed_crc, output ready
    );
endinterface

>>> design/msp_v2_frame_parser.sv
// msp v2 native frame parser with crc-8 dvb-s2 check
// i_in carries one received byte per word plus a buffer_start flag that
// forces the parser back to idle before that byte is looked at.
// o_out gives exactly one result word per input word: an event code
// (none, payload byte, packet ok, crc error, overflow abort, bad direction),
// the streamed payload byte and its index, and the header fields and
// running crc as they stand after that byte.
// a word accepted on i_in goes through the input register, then through the
// parse logic into the result register, before it appears on o_out.
// throughput: one word per cycle while o_out is not stalled, set by the
// combinational crc fold and phase update between the two registers.
// a stalled o_out holds its word; an empty input register still takes one more
// word, then i_in.ready drops until o_out.ready returns.
// reset clears the phase to idle, the header fields and crc to zero and
// empties both registers; there is no clearing pass.
module msp_v2_frame_parser
    import mfp_pkg::*;
#(
    parameter int unsigned PAYLOAD_BUFFER_BYTES = PAYLOAD_BUFFER_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfp_in_if.sink    i_in,
    mfp_out_if.source o_out
);

    logic       stage_valid;
    t_in_word   stage_word;
    logic       take;
    t_core_stat stat;

    mfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_word  (stage_word)
    );

    mfp_parse_core #(
        .PAYLOAD_BUFFER_BYTES (PAYLOAD_BUFFER_BYTES)
    ) u_parse_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_word  (stage_word),
        .o_take  (take),
        .o_stat  (stat),
        .o_out   (o_out)
    );

    // a streamed payload byte always lies inside the announced size
    a_pay_index_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.event_res == EV_PAYLOAD)
            |-> (16'(o_out.payload_index) < o_out.payload_length))
        else $error("payload index beyond payload length");

    // checksum and abort events leave the parser idle; this asserts only idle, check or payload
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fire && ((stat.phase == PH_CHECK) || (stat.phase == PH_PAYLOAD))
            && !stage_word.buffer_start && !(o_out.valid && !o_out.ready)
            |=> (stat.phase == PH_IDLE) || (stat.phase == PH_CHECK)
                || (stat.phase == PH_PAYLOAD))
        else $error("parser left payload or check phase wrongly");

    // a word into an empty pipe passes the input register and the result register to reach the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && !stage_valid && !o_out.valid |-> ##2 o_out.valid)
        else $error("result word missing after two cycles");

    // the core only takes a word that the input register holds
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fire |-> stage_valid)
        else $error("core took a word from an empty input register");

endmodule

>>> design/mfp_in_stage.sv
module mfp_in_stage
    import mfp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    mfp_in_if.sink   i_in,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word.data_byte    <= i_in.data_byte;
            r_word.buffer_start <= i_in.buffer_start;
        end
    end

endmodule

>>> design/mfp_parse_core.sv
module mfp_parse_core
    import mfp_pkg::*;
#(
    parameter int unsigned PAYLOAD_BUFFER_BYTES = PAYLOAD_BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_word   i_word,
    output logic       o_take,
    output t_core_stat o_stat,
    mfp_out_if.source  o_out
);

    localparam int unsigned OFF_W = $clog2(PAYLOAD_BUFFER_BYTES + 1);
    localparam logic [OFF_W-1:0] BUF_LIMIT = OFF_W'(PAYLOAD_BUFFER_BYTES);

    localparam logic [2:0] HDR_FLAGS  = 3'd0;
    localparam logic [2:0] HDR_FN_LO  = 3'd1;
    localparam logic [2:0] HDR_FN_HI  = 3'd2;
    localparam logic [2:0] HDR_LEN_LO = 3'd3;

    // parser state
    t_phase           r_phase,   n_phase;
    logic [2:0]       r_hdr_idx, n_hdr_idx;
    logic [OFF_W-1:0] r_pay_idx, n_pay_idx;
    logic [7:0]       r_crc,     n_crc;
    logic [7:0]       r_fn_lo,   n_fn_lo;
    logic [7:0]       r_fn_hi,   n_fn_hi;
    logic [7:0]       r_len_lo,  n_len_lo;
    logic [15:0]      r_function, n_function;
    logic [15:0]      r_length,   n_length;
    logic [7:0]       r_flags,    n_flags;
    logic             r_dir,      n_dir;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    logic   fire;
    t_phase cur_phase;
    t_event ev;
    logic [7:0] c;
    logic [7:0] pbyte;
    logic [7:0] pidx;

    assign fire   = i_valid && (!r_out_valid || o_out.ready);
    assign o_take = fire;
    assign o_stat = '{fire: fire, phase: r_phase};
    assign c      = i_word.data_byte;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_pay_idx  = r_pay_idx;
        n_crc      = r_crc;
        n_fn_lo    = r_fn_lo;
        n_fn_hi    = r_fn_hi;
        n_len_lo   = r_len_lo;
        n_function = r_function;
        n_length   = r_length;
        n_flags    = r_flags;
        n_dir      = r_dir;
        ev         = EV_NONE;
        pbyte      = 8'd0;
        pidx       = 8'd0;
        cur_phase  = i_word.buffer_start ? PH_IDLE : r_phase;

        case (cur_phase)
            PH_DOLLAR: begin
                n_phase = (c == CH_X) ? PH_X : PH_IDLE;
            end
            PH_X: begin
                n_function = 16'd0;
                n_length   = 16'd0;
                n_flags    = 8'd0;
                n_dir      = 1'b0;
                n_hdr_idx  = 3'd0;
                n_pay_idx  = '0;
                n_crc      = 8'd0;
                if (c == CH_LT) begin
                    n_phase = PH_HEADER;
                end else if (c == CH_GT) begin
                    n_dir   = 1'b1;
                    n_phase = PH_HEADER;
                end else begin
                    ev      = EV_DIR;
                    n_phase = PH_IDLE;
                end
            end
            PH_HEADER: begin
                n_crc     = crc8_fold(r_crc, c);
                n_hdr_idx = r_hdr_idx + 3'd1;
                case (r_hdr_idx)
                    HDR_FLAGS:  n_flags  = c;
                    HDR_FN_LO:  n_fn_lo  = c;
                    HDR_FN_HI:  n_fn_hi  = c;
                    HDR_LEN_LO: n_len_lo = c;
                    default: begin
                        // size high byte closes the header
                        n_function = {r_fn_hi, r_fn_lo};
                        n_length   = {c, r_len_lo};
                        n_hdr_idx  = 3'd0;
                        n_pay_idx  = '0;
                        n_phase    = ({c, r_len_lo} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                endcase
            end
            PH_PAYLOAD: begin
                if (r_pay_idx < BUF_LIMIT) begin
                    ev        = EV_PAYLOAD;
                    pbyte     = c;
                    pidx      = 8'(r_pay_idx);
                    n_crc     = crc8_fold(r_crc, c);
                    n_pay_idx = r_pay_idx + OFF_W'(1);
                    if (16'(n_pay_idx) == r_length) begin
                        n_phase = PH_CHECK;
                    end
                end else begin
                    ev      = EV_OVERFLOW;
                    n_phase = PH_IDLE;
                end
            end
            PH_CHECK: begin
                ev      = (r_crc == c) ? EV_OK : EV_CRC;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = (c == CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
            end
        endcase

        n_out.event_res      = ev;
        n_out.payload_byte   = pbyte;
        n_out.payload_index  = pidx;
        n_out.function_code  = n_function;
        n_out.payload_length = n_length;
        n_out.header_flags   = n_flags;
        n_out.is_response    = n_dir;
        n_out.computed_crc   = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hdr_idx   <= 3'd0;
            r_pay_idx   <= '0;
            r_crc       <= 8'd0;
            r_function  <= 16'd0;
            r_length    <= 16'd0;
            r_flags     <= 8'd0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase    <= n_phase;
                r_hdr_idx  <= n_hdr_idx;
                r_pay_idx  <= n_pay_idx;
                r_crc      <= n_crc;
                r_function <= n_function;
                r_length   <= n_length;
                r_flags    <= n_flags;
                r_dir      <= n_dir;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // header byte collectors, always written before use within a frame, and the result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_fn_lo  <= n_fn_lo;
            r_fn_hi  <= n_fn_hi;
            r_len_lo <= n_len_lo;
            r_out    <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_out.event_res;
    assign o_out.payload_byte   = r_out.payload_byte;
    assign o_out.payload_index  = r_out.payload_index;
    assign o_out.function_code  = r_out.function_code;
    assign o_out.payload_length = r_out.payload_length;
    assign o_out.header_flags   = r_out.header_flags;
    assign o_out.is_response    = r_out.is_response;
    assign o_out.computed_crc   = r_out.computed_crc;

endmodule
